// File: rtl/core/lsc_pkg.sv
// shared types and constants for the lru set-associative cache model
`timescale 1ns / 1ps
package lsc_pkg;

  // access kinds that the logic tells apart
  localparam logic [1:0] FUNC_MODIFY = 2'd2;
  localparam logic [1:0] FUNC_OTHER  = 2'd3;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BITS  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WAYS_IN_USE = 2'd2;

  // register reset values
  localparam logic [2:0] RST_SET_BITS    = 3'd4;
  localparam logic [4:0] RST_BLOCK_BITS  = 5'd4;
  localparam logic [3:0] RST_WAYS_IN_USE = 4'd8;

  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  localparam int CNT_W  = 32;

  // one access beat
  typedef struct packed {
    logic [1:0]        func;
    logic [ADDR_W-1:0] address;
  } access_t;

  // one result beat
  typedef struct packed {
    logic [1:0]       hits_added;
    logic             was_miss;
    logic             was_evict;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } result_t;

endpackage

// File: rtl/core/lsc_queue.sv
// short fifo between the decode front and the lookup back end
`timescale 1ns / 1ps
module lsc_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign rdata = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && valid) begin
        rd_ptr <= ~rd_ptr;
      end
      if ((push && !full) && !(pop && valid)) begin
        count <= count + 2'd1;
      end else if (!(push && !full) && (pop && valid)) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/lsc_front.sv
// configuration registers and access decode into set index, tag and way limit
`timescale 1ns / 1ps
module lsc_front #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int ADDR_BITS    = 32,
  parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  parameter int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               push,
  output logic                               full,
  input  lsc_pkg::access_t                   access,
  input  logic                               clearing,
  input  logic                               q_full,
  output logic                               q_push,
  output logic [1:0]                         q_func,
  output logic [SET_W-1:0]                   q_set,
  output logic [lsc_pkg::TAG_W-1:0]          q_tag,
  output logic [WAY_W-1:0]                   q_last
);

  localparam logic [lsc_pkg::ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= lsc_pkg::ADDR_W) ? '1 :
    lsc_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic [2:0] set_bits;
  logic [4:0] block_bits;
  logic [3:0] ways_in_use;

  logic [lsc_pkg::ADDR_W-1:0] addr_m;
  logic [2:0]                 sb;
  logic [5:0]                 shift;
  logic [lsc_pkg::ADDR_W-1:0] set_full;
  logic [5:0]                 ways6;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= lsc_pkg::RST_SET_BITS;
      block_bits  <= lsc_pkg::RST_BLOCK_BITS;
      ways_in_use <= lsc_pkg::RST_WAYS_IN_USE;
    end else if (cfg_write) begin
      case (cfg_index)
        lsc_pkg::REG_SET_BITS:    set_bits    <= cfg_data[2:0];
        lsc_pkg::REG_BLOCK_BITS:  block_bits  <= cfg_data[4:0];
        lsc_pkg::REG_WAYS_IN_USE: ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // no beats taken while the back end clears its valid bits
  assign full   = q_full || clearing;
  assign q_push = push && !full;
  assign q_func = access.func;

  // address split and way limit
  always_comb begin
    addr_m = access.address & ADDR_MASK;
    if (32'(set_bits) > 32'(MAX_SET_BITS)) begin
      sb = 3'(MAX_SET_BITS);
    end else begin
      sb = set_bits;
    end
    shift = 6'(block_bits) + 6'(sb);
    if (7'(shift) >= 7'(ADDR_BITS)) begin
      q_tag = '0;
    end else begin
      q_tag = addr_m & ({lsc_pkg::ADDR_W{1'b1}} << shift);
    end
    set_full = (addr_m >> block_bits) & ~({lsc_pkg::ADDR_W{1'b1}} << sb);
    q_set    = set_full[SET_W-1:0];
    ways6    = 6'(ways_in_use);
    if (ways6 == 6'd0) begin
      ways6 = 6'd1;
    end else if (ways6 > 6'(WAYS)) begin
      ways6 = 6'(WAYS);
    end
    q_last = WAY_W'(ways6 - 6'd1);
  end

endmodule

// File: rtl/core/lsc_back.sv
// set memory, tag lookup, lru reorder, saturating totals and result register
`timescale 1ns / 1ps
module lsc_back #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
  parameter int WAY_W        = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  logic [1:0]                q_func,
  input  logic [SET_W-1:0]          q_set,
  input  logic [lsc_pkg::TAG_W-1:0] q_tag,
  input  logic [WAY_W-1:0]          q_last,
  output logic                      clearing,
  output logic                      empty,
  input  logic                      pop,
  output lsc_pkg::result_t          result
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int TAG_W    = lsc_pkg::TAG_W;
  localparam int CNT_W    = lsc_pkg::CNT_W;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  // set memory: one row per set
  logic [WAYS-1:0]            mem_valid [NUM_SETS];
  logic [WAYS-1:0][TAG_W-1:0] mem_tag   [NUM_SETS];

  logic [1:0]       state;
  logic [SET_W-1:0] clr_idx;

  logic [1:0]       cur_func;
  logic [SET_W-1:0] cur_set;
  logic [TAG_W-1:0] cur_tag;
  logic [WAY_W-1:0] cur_last;

  logic [WAYS-1:0]            rd_valid;
  logic [WAYS-1:0][TAG_W-1:0] rd_tag;

  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;
  logic [CNT_W-1:0] evict_count;
  logic             out_valid;

  logic [WAYS-1:0]            match;
  logic                       hit;
  logic [WAY_W-1:0]           found;
  logic [WAYS-1:0]            new_valid;
  logic [WAYS-1:0][TAG_W-1:0] new_tag;
  logic [1:0]                 hits;
  logic                       miss;
  logic                       evict;
  logic                       active;
  logic                       do_update;
  logic [CNT_W:0]             hit_sum;
  logic [CNT_W:0]             miss_sum;
  logic [CNT_W:0]             evict_sum;
  logic [CNT_W-1:0]           hit_count_next;
  logic [CNT_W-1:0]           miss_count_next;
  logic [CNT_W-1:0]           evict_count_next;

  assign clearing  = (state == ST_CLEAR);
  assign q_pop     = (state == ST_READ) && q_valid;
  assign do_update = (state == ST_UPDATE) && (!out_valid || pop);
  assign active    = (cur_func != lsc_pkg::FUNC_OTHER);
  assign empty     = !out_valid;

  // compare the ways in use of the set, then move the hit or newly filled line to the front
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = rd_valid[i] && (rd_tag[i] == cur_tag) && (i <= int'(cur_last));
    end
    hit   = |match;
    found = cur_last;
    if (hit) begin
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (match[i]) begin
          found = WAY_W'(i);
        end
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      if (i == 0) begin
        new_valid[i] = 1'b1;
        new_tag[i]   = cur_tag;
      end else if (i <= int'(found)) begin
        new_valid[i] = rd_valid[i-1];
        new_tag[i]   = rd_tag[i-1];
      end else begin
        new_valid[i] = rd_valid[i];
        new_tag[i]   = rd_tag[i];
      end
    end
    if (!active) begin
      hits  = 2'd0;
      miss  = 1'b0;
      evict = 1'b0;
    end else if (hit) begin
      hits  = (cur_func == lsc_pkg::FUNC_MODIFY) ? 2'd2 : 2'd1;
      miss  = 1'b0;
      evict = 1'b0;
    end else begin
      hits  = (cur_func == lsc_pkg::FUNC_MODIFY) ? 2'd1 : 2'd0;
      miss  = 1'b1;
      evict = rd_valid[cur_last];
    end
  end

  // saturating totals
  always_comb begin
    hit_sum          = {1'b0, hit_count} + (CNT_W + 1)'(hits);
    miss_sum         = {1'b0, miss_count} + (CNT_W + 1)'(miss);
    evict_sum        = {1'b0, evict_count} + (CNT_W + 1)'(evict);
    hit_count_next   = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
    miss_count_next  = miss_sum[CNT_W] ? '1 : miss_sum[CNT_W-1:0];
    evict_count_next = evict_sum[CNT_W] ? '1 : evict_sum[CNT_W-1:0];
  end

  // set memory write: clearing pass or write back of the reordered row
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      mem_valid[clr_idx] <= '0;
    end else if (do_update && active) begin
      mem_valid[cur_set] <= new_valid;
      mem_tag[cur_set]   <= new_tag;
    end
  end

  // set memory read and item capture
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_valid <= mem_valid[q_set];
      rd_tag   <= mem_tag[q_set];
      cur_func <= q_func;
      cur_set  <= q_set;
      cur_tag  <= q_tag;
      cur_last <= q_last;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (clr_idx == SET_W'(NUM_SETS - 1)) begin
            state <= ST_READ;
          end
          clr_idx <= clr_idx + SET_W'(1);
        end
        ST_READ: begin
          if (q_valid) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (do_update) begin
            state <= ST_READ;
          end
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // totals and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count   <= '0;
      miss_count  <= '0;
      evict_count <= '0;
      out_valid   <= 1'b0;
    end else if (do_update) begin
      hit_count   <= hit_count_next;
      miss_count  <= miss_count_next;
      evict_count <= evict_count_next;
      out_valid   <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      result.hits_added  <= hits;
      result.was_miss    <= miss;
      result.was_evict   <= evict;
      result.hit_total   <= hit_count_next;
      result.miss_total  <= miss_count_next;
      result.evict_total <= evict_count_next;
    end
  end

endmodule

// File: rtl/core/lru_set_assoc_cache_model_unit.sv
// top level: lru set-associative cache model with queue-style ports
// an access beat passes through the queue, the set row read and item capture, then the result register
// the back end takes a new access only after the write back of the last one's set row
// a two-entry queue in front lets accesses be taken while a result waits to be popped
// reset: clears totals, loads set_bits 4, block_bits 4, ways_in_use 8, then a valid-bit
// clearing pass over all 2**MAX_SET_BITS sets (64 by default) holds full high
`timescale 1ns / 1ps
module lru_set_assoc_cache_model_unit #(
  parameter int MAX_SET_BITS = 6,
  parameter int WAYS         = 8,
  parameter int ADDR_BITS    = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [lsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            push,
  output logic                            full,
  input  lsc_pkg::access_t                access,
  output logic                            empty,
  input  logic                            pop,
  output lsc_pkg::result_t                result
);

  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ITEM_W = 2 + SET_W + lsc_pkg::TAG_W + WAY_W;

  logic                      clearing;
  logic                      q_full;
  logic                      q_push;
  logic                      q_pop;
  logic                      q_valid;
  logic [1:0]                f_func;
  logic [SET_W-1:0]          f_set;
  logic [lsc_pkg::TAG_W-1:0] f_tag;
  logic [WAY_W-1:0]          f_last;
  logic [ITEM_W-1:0]         q_wdata;
  logic [ITEM_W-1:0]         q_rdata;
  logic [1:0]                b_func;
  logic [SET_W-1:0]          b_set;
  logic [lsc_pkg::TAG_W-1:0] b_tag;
  logic [WAY_W-1:0]          b_last;

  // decode front
  lsc_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS),
    .ADDR_BITS    (ADDR_BITS),
    .SET_W        (SET_W),
    .WAY_W        (WAY_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .access    (access),
    .clearing  (clearing),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_func    (f_func),
    .q_set     (f_set),
    .q_tag     (f_tag),
    .q_last    (f_last)
  );

  // decoded item queue
  assign q_wdata = {f_func, f_set, f_tag, f_last};

  lsc_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  assign {b_func, b_set, b_tag, b_last} = q_rdata;

  // lookup back end
  lsc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .WAYS         (WAYS),
    .SET_W        (SET_W),
    .WAY_W        (WAY_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_func   (b_func),
    .q_set    (b_set),
    .q_tag    (b_tag),
    .q_last   (b_last),
    .clearing (clearing),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
